/* hdl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the same, for readability at the call site.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/wpms_pkg.sv */
`default_nettype none

package wpms_pkg;

    // Coordinate width in millimetres, signed.
    localparam int CoordW = 24;
    // Squared distance: two 24-bit squares summed.
    localparam int DistW = 2 * CoordW + 1;
    localparam int RadW = 16;

    // Word kinds.
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_POSITION = 2'd2;

    // Point classes for loads.
    localparam logic [1:0] CLS_ORDINARY = 2'd0;
    localparam logic [1:0] CLS_ENDPOINT = 2'd1;
    localparam logic [1:0] CLS_TURNING = 2'd2;
    localparam logic [1:0] CLS_SLOPE = 2'd3;

    // Result modes.
    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_SLOPE_SLOW = 2'd1;
    localparam logic [1:0] MODE_SLOW = 2'd2;
    localparam logic [1:0] MODE_NORMAL = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_NEAR = 2'd0;
    localparam logic [1:0] REG_STOP = 2'd1;
    localparam logic [1:0] REG_SLOWDOWN = 2'd2;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
    } t_point;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic [1:0]               point_class;
    } t_in_word;

    typedef struct packed {
        logic [1:0] mode;
        logic       last;
    } t_out_word;

    // Tag that travels with a point through the distance pipeline.
    typedef struct packed {
        logic vld;
        logic is_end;
    } t_tag;

endpackage

`default_nettype wire

/* hdl/waypoint_proximity_mode_select_top.sv */
// Channel   Direction  Handshake            Word
// input     in         i_in_valid/o_in_stall   t_in_word (kind, pos_x, pos_y, point_class)
// output    out        o_out_valid/i_out_stall t_out_word (mode, last)
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// Loads, clears and positions that find both tables empty are accepted without stalling the input.
// A position scan rotates the point rings through the distance units and then
// delivers its result words.
// Reset is synchronous and active low; it empties both tables, puts the
// endpoint at the origin and restores the radius registers.
// The input is stalled from the acceptance of a position that starts a scan until its last word leaves.
`default_nettype none

module waypoint_proximity_mode_select_top
    import wpms_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_word   i_in_word,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_word       o_out_word,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [RadW-1:0] i_cfg_data
);

    localparam int CntW = $clog2(MAX_POINTS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WAIT  = 5'b00100,
        S_EARLY = 5'b01000,
        S_FINAL = 5'b10000
    } t_state;

    t_state r_state;
    logic [RadW-1:0]   r_near, r_stop, r_slow;
    logic [2*RadW-1:0] r_near_sq, r_stop_sq, r_slow_sq;
    logic [CntW-1:0]   r_slope_cnt, r_turn_cnt, r_k;
    t_point            r_end, r_pos;
    logic              r_slope_hit, r_turn_hit;
    t_out_word         r_out;
    logic [1:0]        r_final_mode;

    logic   in_acc, out_acc, load_slope, load_turn, shift, at_end;
    t_point new_pt;
    t_point slope_pt [MAX_POINTS];
    t_point turn_pt  [MAX_POINTS];
    t_tag   slope_tag_in, turn_tag_in, slope_tag_out, turn_tag_out;
    t_point slope_feed;
    logic [DistW-1:0] slope_dsq, turn_dsq;
    logic   near_slope, near_turn, end_done;
    logic [1:0] n_final_mode;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign new_pt  = '{x: i_in_word.pos_x, y: i_in_word.pos_y};

    assign load_slope = in_acc && i_in_word.kind == KIND_LOAD
                        && i_in_word.point_class == CLS_SLOPE
                        && r_slope_cnt < CntW'(MAX_POINTS);
    assign load_turn  = in_acc && i_in_word.kind == KIND_LOAD
                        && i_in_word.point_class == CLS_TURNING
                        && r_turn_cnt < CntW'(MAX_POINTS);

    assign at_end = r_k == CntW'(MAX_POINTS);
    assign shift  = r_state == S_SCAN && !at_end;

    // Two rings of point cells; a scan rotates each ring once around.
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cells
        wpms_cell u_slope (
            .i_clk     (i_clk),
            .i_wr      (load_slope && r_slope_cnt == CntW'(i)),
            .i_shift   (shift),
            .i_new_pt  (new_pt),
            .i_next_pt (slope_pt[(i + 1) % MAX_POINTS]),
            .o_pt      (slope_pt[i])
        );
        wpms_cell u_turn (
            .i_clk     (i_clk),
            .i_wr      (load_turn && r_turn_cnt == CntW'(i)),
            .i_shift   (shift),
            .i_new_pt  (new_pt),
            .i_next_pt (turn_pt[(i + 1) % MAX_POINTS]),
            .o_pt      (turn_pt[i])
        );
    end

    // The slope unit also measures the endpoint after the last slope point.
    always_comb begin
        slope_tag_in.vld    = r_state == S_SCAN && (r_k < r_slope_cnt || at_end);
        slope_tag_in.is_end = r_state == S_SCAN && at_end;
        turn_tag_in.vld     = r_state == S_SCAN && r_k < r_turn_cnt;
        turn_tag_in.is_end  = 1'b0;
        slope_feed          = at_end ? r_end : slope_pt[0];
    end

    wpms_dist u_slope_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (slope_tag_in),
        .i_pos   (r_pos),
        .i_pt    (slope_feed),
        .o_tag   (slope_tag_out),
        .o_dsq   (slope_dsq)
    );

    wpms_dist u_turn_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (turn_tag_in),
        .i_pos   (r_pos),
        .i_pt    (turn_pt[0]),
        .o_tag   (turn_tag_out),
        .o_dsq   (turn_dsq)
    );

    // Compares of the unit outputs against the squared radii.
    always_comb begin
        near_slope = slope_tag_out.vld && !slope_tag_out.is_end
                     && slope_dsq <= DistW'(r_near_sq);
        near_turn  = turn_tag_out.vld && turn_dsq <= DistW'(r_near_sq);
        end_done   = slope_tag_out.vld && slope_tag_out.is_end;
        if (slope_dsq <= DistW'(r_stop_sq)) begin
            n_final_mode = MODE_STOP;
        end else if (slope_dsq <= DistW'(r_slow_sq)) begin
            n_final_mode = MODE_SLOW;
        end else if (r_slope_hit) begin
            n_final_mode = MODE_SLOPE_SLOW;
        end else if (r_turn_hit) begin
            n_final_mode = MODE_SLOW;
        end else begin
            n_final_mode = MODE_NORMAL;
        end
    end

    // Radius registers and their squares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= RadW'(1000);
            r_stop <= RadW'(500);
            r_slow <= RadW'(2000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NEAR:     r_near <= i_cfg_data;
                REG_STOP:     r_stop <= i_cfg_data;
                REG_SLOWDOWN: r_slow <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_near_sq <= r_near * r_near;
        r_stop_sq <= r_stop * r_stop;
        r_slow_sq <= r_slow * r_slow;
    end

    // Table counts and the endpoint.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope_cnt <= '0;
            r_turn_cnt  <= '0;
            r_end       <= '0;
        end else if (in_acc && i_in_word.kind == KIND_CLEAR) begin
            r_slope_cnt <= '0;
            r_turn_cnt  <= '0;
        end else begin
            if (load_slope) begin
                r_slope_cnt <= r_slope_cnt + CntW'(1);
            end
            if (load_turn) begin
                r_turn_cnt <= r_turn_cnt + CntW'(1);
            end
            if (in_acc && i_in_word.kind == KIND_LOAD
                    && i_in_word.point_class == CLS_ENDPOINT) begin
                r_end <= new_pt;
            end
        end
    end

    // Position latch.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos <= new_pt;
        end
    end

    // Scan sequencer and output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_slope_hit  <= 1'b0;
            r_turn_hit   <= 1'b0;
            r_out        <= '0;
            r_final_mode <= MODE_NORMAL;
        end else begin
            unique case (r_state) inside
                S_IDLE: begin
                    if (in_acc && i_in_word.kind == KIND_POSITION
                            && (r_slope_cnt != '0 || r_turn_cnt != '0)) begin
                        r_state     <= S_SCAN;
                        r_k         <= '0;
                        r_slope_hit <= 1'b0;
                        r_turn_hit  <= 1'b0;
                    end
                end
                S_SCAN, S_WAIT: begin
                    if (r_state == S_SCAN) begin
                        r_k <= r_k + CntW'(1);
                        if (at_end) begin
                            r_state <= S_WAIT;
                        end
                    end
                    if (near_slope) begin
                        r_slope_hit <= 1'b1;
                    end
                    if (near_turn) begin
                        r_turn_hit <= 1'b1;
                    end
                    if (end_done) begin
                        r_final_mode <= n_final_mode;
                        if (r_slope_hit || r_turn_hit) begin
                            r_out   <= '{mode: r_slope_hit ? MODE_SLOPE_SLOW : MODE_SLOW,
                                         last: 1'b0};
                            r_state <= S_EARLY;
                        end else begin
                            r_out   <= '{mode: n_final_mode, last: 1'b1};
                            r_state <= S_FINAL;
                        end
                    end
                end
                S_EARLY: begin
                    if (out_acc) begin
                        r_out   <= '{mode: r_final_mode, last: 1'b1};
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    if (out_acc) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_state == S_EARLY || r_state == S_FINAL;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

/* hdl/wpms_cell.sv */
`default_nettype none

module wpms_cell
    import wpms_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_wr,
    input  wire logic   i_shift,
    input  wire t_point i_new_pt,
    input  wire t_point i_next_pt,
    output t_point      o_pt
);

    t_point r_pt;

    // A load writes this cell; a scan step takes the neighbor's point.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_pt <= i_new_pt;
        end else if (i_shift) begin
            r_pt <= i_next_pt;
        end
    end

    assign o_pt = r_pt;

endmodule

`default_nettype wire

/* hdl/wpms_dist.sv */
`default_nettype none

module wpms_dist
    import wpms_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_tag   i_tag,
    input  wire t_point i_pos,
    input  wire t_point i_pt,
    output t_tag        o_tag,
    output logic [DistW-1:0] o_dsq
);

    logic signed [CoordW:0] dx, dy;
    logic [CoordW-1:0]      r_ax, r_ay;
    logic [2*CoordW-1:0]    r_sx, r_sy;
    logic [DistW-1:0]       r_dsq;
    t_tag                   r_tag1, r_tag2, r_tag3;

    // Differences at full width; their magnitude always fits 24 bits.
    assign dx = CoordW'(0) + ({i_pos.x[CoordW-1], i_pos.x} - {i_pt.x[CoordW-1], i_pt.x});
    assign dy = CoordW'(0) + ({i_pos.y[CoordW-1], i_pos.y} - {i_pt.y[CoordW-1], i_pt.y});

    // Stage one: magnitudes. Stage two: squares. Stage three: sum.
    always_ff @(posedge i_clk) begin
        r_ax  <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
        r_ay  <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
        r_sx  <= r_ax * r_ax;
        r_sy  <= r_ay * r_ay;
        r_dsq <= DistW'(r_sx) + DistW'(r_sy);
    end

    // The tag walks alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    assign o_tag = r_tag3;
    assign o_dsq = r_dsq;

endmodule

`default_nettype wire

/* hdl/wpms_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module wpms_checker
    import wpms_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_word  i_in_word,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    // A stalled output word holds.
    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, ##1 (o_out_valid && $stable(o_out_word)), "stalled output word changed")

    // No new input is taken while a result word is pending.
    `ASSERT_IMPL(a_in_blocked, i_clk, i_rst_n, o_out_valid, o_in_stall, "input open while result pending")

    // An early word is followed at once by the final word.
    `ASSERT_IMPL(a_final_follows, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out_word.last, ##1 (o_out_valid && o_out_word.last), "final word missing after early word")

    // An early word carries only a slowdown mode.
    `ASSERT_IMPL(a_early_mode, i_clk, i_rst_n, o_out_valid && !o_out_word.last, o_out_word.mode == MODE_SLOPE_SLOW || o_out_word.mode == MODE_SLOW, "bad early mode")

    // Loads and clears produce no result.
    `ASSERT_IMPL(a_no_result, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_word.kind != KIND_POSITION, ##1 !o_out_valid, "result after non-position word")

endmodule

bind waypoint_proximity_mode_select_top wpms_checker u_wpms_checker (.*);

`default_nettype wire

/* verif/wpms_mode_checker.sv */
`timescale 1ns / 100ps

module wpms_mode_checker
    import wpms_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_stall,
    input  wire t_in_word        i_in_word,
    input  wire logic            i_out_valid,
    input  wire logic            i_out_stall,
    input  wire t_out_word       i_out_word,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [RadW-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // Keeps the log short when the block is badly broken; every mismatch is still counted.
    localparam int MaxPrinted = 100;

    // Our own copy of the radius registers, point tables and endpoint.
    logic [RadW-1:0] near_r;
    logic [RadW-1:0] stop_r;
    logic [RadW-1:0] slow_r;
    t_point          slope_tab [MAX_POINTS];
    t_point          turn_tab [MAX_POINTS];
    int              slope_n;
    int              turn_n;
    t_point          end_pt;

    // Mode words the block still owes, oldest first.
    t_out_word       mode_queue [$];
    int              fail_count = 0;

    // Squared distance from a stored point, exact in 64-bit arithmetic.
    function automatic longint dist_sq(t_point p, logic signed [CoordW-1:0] px,
                                       logic signed [CoordW-1:0] py);
        longint dx;
        longint dy;
        dx = longint'(px) - longint'($signed(p.x));
        dy = longint'(py) - longint'($signed(p.y));
        return dx * dx + dy * dy;
    endfunction

    // True when any filled entry of the chosen table lies within the squared radius.
    function automatic bit table_hit(bit slope_side, logic signed [CoordW-1:0] px,
                                     logic signed [CoordW-1:0] py, longint r2);
        int n;
        int i;
        n = slope_side ? slope_n : turn_n;
        for (i = 0; i < n; i++) begin
            if (slope_side ? (dist_sq(slope_tab[i], px, py) <= r2)
                           : (dist_sq(turn_tab[i], px, py) <= r2)) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        if (fail_count <= MaxPrinted) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Appends one owed word at the tail of the queue.
    task automatic owe_word(t_out_word w);
        mode_queue = {mode_queue, w};
    endtask

    // Applies one accepted input word and queues the mode words it should cause.
    task automatic predict_modes(t_in_word w);
        longint     r2;
        longint     d2;
        logic [1:0] fin;
        t_point     p;
        p.x = w.pos_x;
        p.y = w.pos_y;
        case (w.kind)
            KIND_LOAD: begin
                case (w.point_class)
                    CLS_ENDPOINT: begin
                        end_pt = p;
                    end
                    CLS_TURNING: begin
                        // A full table drops the point.
                        if (turn_n < MAX_POINTS) begin
                            turn_tab[turn_n] = p;
                            turn_n++;
                        end
                    end
                    CLS_SLOPE: begin
                        if (slope_n < MAX_POINTS) begin
                            slope_tab[slope_n] = p;
                            slope_n++;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_CLEAR: begin
                slope_n = 0;
                turn_n = 0;
            end
            KIND_POSITION: begin
                // With both tables empty the position is dropped silently.
                if (slope_n != 0 || turn_n != 0) begin
                    r2 = longint'(near_r) * longint'(near_r);
                    fin = MODE_NORMAL;
                    if (table_hit(1'b1, w.pos_x, w.pos_y, r2)) begin
                        fin = MODE_SLOPE_SLOW;
                        owe_word(t_out_word'{mode: MODE_SLOPE_SLOW, last: 1'b0});
                    end else if (table_hit(1'b0, w.pos_x, w.pos_y, r2)) begin
                        fin = MODE_SLOW;
                        owe_word(t_out_word'{mode: MODE_SLOW, last: 1'b0});
                    end
                    // The endpoint distance overrides whatever the tables gave.
                    d2 = dist_sq(end_pt, w.pos_x, w.pos_y);
                    if (d2 <= longint'(stop_r) * longint'(stop_r)) begin
                        fin = MODE_STOP;
                    end else if (d2 <= longint'(slow_r) * longint'(slow_r)) begin
                        fin = MODE_SLOW;
                    end
                    owe_word(t_out_word'{mode: fin, last: 1'b1});
                end
            end
            default: ;
        endcase
    endtask

    // Watch both channels and the register port on every rising edge.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            near_r = 16'd1000;
            stop_r = 16'd500;
            slow_r = 16'd2000;
            slope_n = 0;
            turn_n = 0;
            end_pt = '0;
            mode_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_NEAR: begin
                        near_r = i_cfg_data;
                    end
                    REG_STOP: begin
                        stop_r = i_cfg_data;
                    end
                    REG_SLOWDOWN: begin
                        slow_r = i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_modes(i_in_word);
            end
            if (i_out_valid && !i_out_stall) begin
                if (mode_queue.size() == 0) begin
                    report_mismatch("word with nothing expected, mode", i_out_word.mode, -1);
                end else begin
                    want = mode_queue.pop_front();
                    if (i_out_word.mode !== want.mode) begin
                        report_mismatch("mode", i_out_word.mode, want.mode);
                    end
                    if (i_out_word.last !== want.last) begin
                        report_mismatch("last", i_out_word.last, want.last);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending <= mode_queue.size();
    end

endmodule

/* verif/waypoint_proximity_mode_select_top_test.sv */
`timescale 1ns / 100ps

module waypoint_proximity_mode_select_top_test;
    import wpms_pkg::*;

    localparam int MAX_POINTS = 64;
    // Kind with no meaning to the block; it must be swallowed.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // A full scan plus both result words, with margin.
    localparam int SETTLE_CYCLES = MAX_POINTS + 20;
    localparam int LONG_HOLD = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS = 30;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    t_in_word        in_word = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    t_out_word       out_word;
    logic            cfg_we = 1'b0;
    logic [1:0]      cfg_index = REG_NEAR;
    logic [RadW-1:0] cfg_data = '0;

    int              fail_count;
    int              pending;
    bit              idle_on = 1'b1;
    bit              hold_req = 1'b0;
    int              items_sent = 0;

    // What the stimulus knows of the current setup, used to aim positions.
    logic [RadW-1:0]          cur_near = 16'd1000;
    logic [RadW-1:0]          cur_stop = 16'd500;
    logic [RadW-1:0]          cur_slow = 16'd2000;
    logic signed [CoordW-1:0] ep_x = '0;
    logic signed [CoordW-1:0] ep_y = '0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    waypoint_proximity_mode_select_top #(
        .MAX_POINTS(MAX_POINTS)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_word(in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word(out_word),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    wpms_mode_checker #(
        .MAX_POINTS(MAX_POINTS)
    ) mode_check (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_in_word(in_word),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_word(out_word),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    function automatic logic signed [CoordW-1:0] rand_coord();
        logic [31:0] v;
        v = $urandom;
        return v[CoordW-1:0];
    endfunction

    // Centers stay clear of the coordinate limits so offsets never wrap.
    function automatic logic signed [CoordW-1:0] rand_center();
        int v;
        v = int'($urandom_range(0, 16000000)) - 8000000;
        return v[CoordW-1:0];
    endfunction

    // Moves a coordinate by a fixed offset plus a random one within +/- span.
    function automatic logic signed [CoordW-1:0] nudge(logic signed [CoordW-1:0] base,
                                                       int off, int span);
        int v;
        v = int'(base) + off + int'($urandom_range(0, 2 * span)) - span;
        if (v > 8388607) begin
            v = 8388607;
        end
        if (v < -8388608) begin
            v = -8388608;
        end
        return v[CoordW-1:0];
    endfunction

    // Offers one word and holds it until the block takes it, then maybe idles.
    task automatic send_word(logic [1:0] k, logic signed [CoordW-1:0] x,
                             logic signed [CoordW-1:0] y, logic [1:0] cls);
        t_in_word w;
        w.kind = k;
        w.pos_x = x;
        w.pos_y = y;
        w.point_class = cls;
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (k == KIND_LOAD && cls == CLS_ENDPOINT) begin
            ep_x = x;
            ep_y = y;
        end
        if (k != KIND_UNUSED && !(k == KIND_LOAD && cls == CLS_ORDINARY)) begin
            items_sent++;
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Stops offering, waits for every owed word, then lets a scan's worth pass.
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radii(logic [RadW-1:0] near_v, logic [RadW-1:0] stop_v,
                               logic [RadW-1:0] slow_v);
        cfg_we <= 1'b1;
        cfg_index <= REG_NEAR;
        cfg_data <= near_v;
        @(posedge clk);
        cfg_index <= REG_STOP;
        cfg_data <= stop_v;
        @(posedge clk);
        cfg_index <= REG_SLOWDOWN;
        cfg_data <= slow_v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_near = near_v;
        cur_stop = stop_v;
        cur_slow = slow_v;
    endtask

    // Any word at all, full-range fields.
    task automatic send_noise();
        send_word(2'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                  2'($urandom_range(0, 3)));
    endtask

    // A route around one center: optional clear and endpoint, a few points,
    // then positions aimed at the points, the endpoint and the radius edges.
    task automatic run_sequence();
        t_point                   pts [8];
        int                       npts;
        int                       span;
        int                       r;
        int                       pick;
        logic [1:0]               cls;
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] tx;
        logic signed [CoordW-1:0] ty;
        npts = 0;
        span = 3 * int'(cur_near) + 50;
        cx = rand_center();
        cy = rand_center();
        if ($urandom_range(0, 3) == 0) begin
            send_word(KIND_CLEAR, rand_coord(), rand_coord(), 2'($urandom_range(0, 3)));
        end
        if ($urandom_range(0, 3) != 0) begin
            send_word(KIND_LOAD, nudge(cx, 0, int'(cur_slow) + 50),
                      nudge(cy, 0, int'(cur_slow) + 50), CLS_ENDPOINT);
        end
        repeat ($urandom_range(0, 8)) begin
            tx = nudge(cx, 0, span);
            ty = nudge(cy, 0, span);
            cls = $urandom_range(0, 1) ? CLS_SLOPE : CLS_TURNING;
            send_word(KIND_LOAD, tx, ty, cls);
            pts[npts] = t_point'{x: tx, y: ty};
            npts++;
        end
        repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(0, 9);
            if (pick < 5 && npts > 0) begin
                pick = $urandom_range(0, npts - 1);
                tx = pts[pick].x;
                ty = pts[pick].y;
                r = int'(cur_near);
            end else if (pick < 8) begin
                tx = ep_x;
                ty = ep_y;
                r = $urandom_range(0, 1) ? int'(cur_stop) : int'(cur_slow);
            end else begin
                tx = cx;
                ty = cy;
                r = span;
            end
            if ($urandom_range(0, 2) == 0) begin
                // Land exactly on the radius, or one millimetre past it, along an axis.
                r = r + $urandom_range(0, 1);
                if ($urandom_range(0, 1) == 1) begin
                    r = -r;
                end
                if ($urandom_range(0, 1) == 1) begin
                    tx = nudge(tx, r, 0);
                end else begin
                    ty = nudge(ty, r, 0);
                end
            end else begin
                tx = nudge(tx, 0, r + 2);
                ty = nudge(ty, 0, r + 2);
            end
            send_word(KIND_POSITION, tx, ty, 2'($urandom_range(0, 3)));
        end
    endtask

    // Overfills both tables; the extra points sit where the positions then look.
    task automatic fill_tables();
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] tx;
        logic signed [CoordW-1:0] ty;
        sx = rand_center();
        sy = rand_center();
        tx = rand_center();
        ty = rand_center();
        send_word(KIND_CLEAR, '0, '0, CLS_ORDINARY);
        repeat (MAX_POINTS) send_word(KIND_LOAD, rand_coord(), rand_coord(), CLS_SLOPE);
        repeat (3) send_word(KIND_LOAD, sx, sy, CLS_SLOPE);
        repeat (MAX_POINTS) send_word(KIND_LOAD, rand_coord(), rand_coord(), CLS_TURNING);
        repeat (3) send_word(KIND_LOAD, tx, ty, CLS_TURNING);
        send_word(KIND_POSITION, sx, sy, CLS_ORDINARY);
        send_word(KIND_POSITION, tx, ty, CLS_ORDINARY);
        send_word(KIND_POSITION, rand_coord(), rand_coord(), CLS_ORDINARY);
    endtask

    // Result side: random stall bursts, and one long hold-off on request.
    initial begin : receiver
        bit hold_served;
        hold_served = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Ends the run when neither channel moves a word for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int phase_end;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset radii, endpoint at the origin.
        send_word(KIND_POSITION, 24'sd100, 24'sd100, CLS_ORDINARY);
        send_word(KIND_LOAD, 24'sd5000, 24'sd5000, CLS_ORDINARY);
        send_word(KIND_UNUSED, 24'sd5000, 24'sd5000, CLS_TURNING);
        send_word(KIND_POSITION, 24'sd5000, 24'sd5000, CLS_ORDINARY);
        send_word(KIND_LOAD, 24'sd5000, 24'sd5000, CLS_TURNING);
        send_word(KIND_POSITION, 24'sd6000, 24'sd5000, CLS_ORDINARY);
        send_word(KIND_POSITION, 24'sd6001, 24'sd5000, CLS_ORDINARY);
        send_word(KIND_POSITION, 24'sd500, 24'sd0, CLS_ORDINARY);
        send_word(KIND_POSITION, 24'sd0, 24'sd501, CLS_ORDINARY);
        send_word(KIND_POSITION, 24'sd2000, 24'sd0, CLS_ORDINARY);
        send_word(KIND_POSITION, 24'sd0, -24'sd2001, CLS_ORDINARY);
        send_word(KIND_LOAD, -24'sd8388608, 24'sd8388607, CLS_SLOPE);
        send_word(KIND_POSITION, -24'sd8388608, 24'sd8388607, CLS_ORDINARY);
        send_word(KIND_POSITION, 24'sd8388607, -24'sd8388608, CLS_ORDINARY);
        send_word(KIND_LOAD, 24'sd8388607, -24'sd8388608, CLS_ENDPOINT);
        send_word(KIND_POSITION, 24'sd8388607, -24'sd8388608, CLS_ORDINARY);
        send_word(KIND_LOAD, 24'sd5000, 24'sd5000, CLS_SLOPE);
        send_word(KIND_POSITION, 24'sd5000, 24'sd5000, CLS_ORDINARY);
        send_word(KIND_CLEAR, 24'sd5000, 24'sd5000, CLS_SLOPE);
        send_word(KIND_POSITION, 24'sd5000, 24'sd5000, CLS_ORDINARY);
        send_word(KIND_LOAD, -24'sd1, -24'sd1, CLS_TURNING);
        send_word(KIND_POSITION, -24'sd1, -24'sd1, CLS_ORDINARY);

        // Random phases, each under its own radii.
        for (phase = 1; phase <= 7; phase++) begin
            settle_block();
            case (phase)
                1: begin
                    write_radii(16'd0, 16'd0, 16'd0);
                end
                2: begin
                    write_radii(16'hFFFF, 16'hFFFF, 16'hFFFF);
                end
                3: begin
                    write_radii(16'($urandom), 16'($urandom), 16'($urandom));
                end
                4: begin
                    write_radii(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1000)),
                                16'($urandom_range(0, 5000)));
                end
                5: begin
                    write_radii(16'd1000, 16'd500, 16'd2000);
                end
                6: begin
                    // Stop radius wider than the slowdown radius.
                    write_radii(16'($urandom_range(0, 4000)), 16'hFFFF,
                                16'($urandom_range(0, 400)));
                end
                default: begin
                    write_radii(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 3000)),
                                16'($urandom_range(0, 9000)));
                end
            endcase
            if (phase == 4) begin
                fill_tables();
            end
            if (phase == 5) begin
                hold_req <= 1'b1;
            end
            if (phase == 7) begin
                idle_on <= 1'b0;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_noise();
                end else begin
                    run_sequence();
                end
            end
        end

        settle_block();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/wpms_pkg.sv
hdl/wpms_cell.sv
hdl/wpms_dist.sv
hdl/waypoint_proximity_mode_select_top.sv
hdl/wpms_checker.sv
verif/wpms_mode_checker.sv
verif/waypoint_proximity_mode_select_top_test.sv
